@@ hdl/i2cbs_pkg.sv @@
// Package for the I2C master bit sequencer: transfer payload types, command
// and phase codes, and default constants.
// Depends on nothing; used by every module of the block.
`default_nettype none

package i2cbs_pkg;

    localparam int TIMEOUT_BITS_DEF = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_SEND_BYTE = 3'd3;
    localparam logic [2:0] CMD_RECV_BYTE = 3'd4;
    localparam logic [2:0] CMD_SEND_ACK  = 3'd5;
    localparam logic [2:0] CMD_WAIT_ACK  = 3'd6;

    localparam logic [2:0] PH_CLK_LOW  = 3'd0;
    localparam logic [2:0] PH_CLK_HIGH = 3'd1;
    localparam logic [2:0] PH_ACK_LOW  = 3'd2;
    localparam logic [2:0] PH_ACK_POLL = 3'd3;
    localparam logic [2:0] PH_ACK_DONE = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       timed_out;
    } out_item_t;

endpackage

`default_nettype wire

@@ hdl/i2cbs_core.sv @@
// Sequencer core: the operation state registers and the per-tick step logic.
// Depends on i2cbs_pkg.
`default_nettype none

module i2cbs_core #(
    parameter int TIMEOUT_BITS = i2cbs_pkg::TIMEOUT_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  i2cbs_pkg::in_item_t  item,
    input  wire  [15:0]          timeout_ticks,
    output i2cbs_pkg::out_item_t result
);

    localparam int CW = (TIMEOUT_BITS + 1 > 17) ? TIMEOUT_BITS + 1 : 17;

    logic [2:0]              op_reg, op_next;
    logic [2:0]              phase_reg, phase_next;
    logic [3:0]              bit_count_reg, bit_count_next;
    logic [7:0]              shift_reg, shift_next;
    logic [7:0]              receive_reg, receive_next;
    logic [TIMEOUT_BITS-1:0] wait_count_reg, wait_count_next;
    logic [1:0]              lines_reg, lines_next;
    logic [1:0]              flags_reg, flags_next;

    logic [TIMEOUT_BITS:0]   wait_inc;
    logic [CW-1:0]           wait_inc_ext;
    logic [CW-1:0]           cap_ext;
    logic [CW-1:0]           limit_ext;
    logic                    scl;
    logic                    sda;
    logic                    busy;
    logic                    done;

    assign wait_inc     = {1'b0, wait_count_reg} + {{TIMEOUT_BITS{1'b0}}, 1'b1};
    assign wait_inc_ext = CW'(wait_inc);
    assign cap_ext      = CW'({1'b0, {TIMEOUT_BITS{1'b1}}});
    assign limit_ext    = CW'(timeout_ticks);

    always_comb
    begin
        op_next         = op_reg;
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        receive_next    = receive_reg;
        wait_count_next = wait_count_reg;
        lines_next      = lines_reg;
        flags_next      = flags_reg;
        scl             = lines_reg[1];
        sda             = lines_reg[0];
        busy            = 1'b0;
        done            = 1'b0;

        if (op_reg == i2cbs_pkg::CMD_NONE &&
            item.command inside {[i2cbs_pkg::CMD_START:i2cbs_pkg::CMD_WAIT_ACK]})
        begin
            op_next        = item.command;
            phase_next     = (item.command == i2cbs_pkg::CMD_WAIT_ACK) ?
                             i2cbs_pkg::PH_ACK_LOW : i2cbs_pkg::PH_CLK_LOW;
            bit_count_next = 4'd0;
            shift_next     = 8'd0;
            if (item.command == i2cbs_pkg::CMD_SEND_BYTE)
            begin
                shift_next = item.tx_byte;
            end
            if (item.command == i2cbs_pkg::CMD_SEND_ACK)
            begin
                shift_next = {7'd0, ~item.ack_to_send};
            end
            if (item.command == i2cbs_pkg::CMD_SEND_BYTE ||
                item.command == i2cbs_pkg::CMD_WAIT_ACK)
            begin
                flags_next      = 2'b00;
                wait_count_next = '0;
            end
        end

        if (op_next != i2cbs_pkg::CMD_NONE)
        begin
            busy = 1'b1;
            case (op_next)
                i2cbs_pkg::CMD_START:
                begin
                    scl = 1'b1;
                    if (phase_next == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        sda        = 1'b1;
                        phase_next = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        sda        = 1'b0;
                        done       = 1'b1;
                        lines_next = 2'b00;
                    end
                end
                i2cbs_pkg::CMD_STOP:
                begin
                    scl = 1'b1;
                    if (phase_next == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        sda        = 1'b0;
                        phase_next = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        sda        = 1'b1;
                        done       = 1'b1;
                        lines_next = 2'b11;
                    end
                end
                i2cbs_pkg::CMD_SEND_ACK:
                begin
                    sda = shift_next[0];
                    if (phase_next == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        scl        = 1'b0;
                        phase_next = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        scl        = 1'b1;
                        done       = 1'b1;
                        lines_next = {1'b0, shift_next[0]};
                    end
                end
                i2cbs_pkg::CMD_RECV_BYTE:
                begin
                    sda = 1'b1;
                    if (phase_next == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        scl        = 1'b0;
                        phase_next = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        scl            = 1'b1;
                        shift_next     = {shift_next[6:0], item.sda_in};
                        bit_count_next = bit_count_next + 4'd1;
                        if (bit_count_next >= 4'd8)
                        begin
                            receive_next = shift_next;
                            done         = 1'b1;
                            lines_next   = 2'b01;
                        end
                        else
                        begin
                            phase_next = i2cbs_pkg::PH_CLK_LOW;
                        end
                    end
                end
                default:
                begin
                    if (phase_next == i2cbs_pkg::PH_CLK_LOW ||
                        phase_next == i2cbs_pkg::PH_CLK_HIGH)
                    begin
                        sda = shift_next[7];
                        if (phase_next == i2cbs_pkg::PH_CLK_LOW)
                        begin
                            scl        = 1'b0;
                            phase_next = i2cbs_pkg::PH_CLK_HIGH;
                        end
                        else
                        begin
                            scl            = 1'b1;
                            shift_next     = {shift_next[6:0], 1'b0};
                            bit_count_next = bit_count_next + 4'd1;
                            phase_next     = (bit_count_next >= 4'd8) ?
                                             i2cbs_pkg::PH_ACK_LOW : i2cbs_pkg::PH_CLK_LOW;
                        end
                    end
                    else if (phase_next == i2cbs_pkg::PH_ACK_LOW)
                    begin
                        scl        = 1'b0;
                        sda        = 1'b1;
                        phase_next = i2cbs_pkg::PH_ACK_POLL;
                    end
                    else if (phase_next == i2cbs_pkg::PH_ACK_POLL)
                    begin
                        scl = 1'b1;
                        sda = 1'b1;
                        if (!item.sda_in)
                        begin
                            flags_next = 2'b01;
                            phase_next = i2cbs_pkg::PH_ACK_DONE;
                        end
                        else if (wait_inc_ext >= limit_ext || wait_inc_ext >= cap_ext)
                        begin
                            flags_next = 2'b10;
                            phase_next = i2cbs_pkg::PH_ACK_DONE;
                        end
                        else
                        begin
                            wait_count_next = wait_inc[TIMEOUT_BITS-1:0];
                        end
                    end
                    else
                    begin
                        scl        = 1'b1;
                        sda        = 1'b1;
                        done       = 1'b1;
                        lines_next = 2'b01;
                    end
                end
            endcase
            if (done)
            begin
                op_next    = i2cbs_pkg::CMD_NONE;
                phase_next = i2cbs_pkg::PH_CLK_LOW;
            end
        end
    end

    always_comb
    begin
        result.scl_level = scl;
        result.sda_level = sda;
        result.busy_res  = busy;
        result.done_res  = done;
        result.rx_byte   = receive_next;
        result.ack_seen  = flags_next[0];
        result.timed_out = flags_next[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= i2cbs_pkg::CMD_NONE;
            phase_reg      <= i2cbs_pkg::PH_CLK_LOW;
            bit_count_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            receive_reg    <= 8'd0;
            wait_count_reg <= '0;
            lines_reg      <= 2'b11;
            flags_reg      <= 2'b00;
        end
        else if (step)
        begin
            op_reg         <= op_next;
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            receive_reg    <= receive_next;
            wait_count_reg <= wait_count_next;
            lines_reg      <= lines_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/i2c_master_bit_sequencer.sv @@
// Top level of the I2C master bit sequencer: input register, sequencer core,
// result register and the timeout register. Depends on i2cbs_pkg, i2cbs_core.
// A tick waits in the input register, passes through the core and is captured
// in the result register when the output is not stalled. Throughput: one tick
// per cycle unless the output stalls, set by the single pass through the core.
// Reset clears all but the data registers; lines read released, timeout 1000 ticks.
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int TIMEOUT_BITS = i2cbs_pkg::TIMEOUT_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  i2cbs_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  wire                  out_stall,
    output i2cbs_pkg::out_item_t out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [15:0]          cfg_data
);

    logic                 in_vld_reg;
    i2cbs_pkg::in_item_t  in_item_reg;
    logic                 out_vld_reg, out_vld_next;
    i2cbs_pkg::out_item_t out_item_reg;
    i2cbs_pkg::out_item_t core_result;
    logic [15:0]          timeout_reg;
    logic                 advance;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else
        begin
            out_vld_next = out_vld_reg && out_stall;
        end
    end

    i2cbs_core #(
        .TIMEOUT_BITS(TIMEOUT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_item_reg),
        .timeout_ticks(timeout_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            timeout_reg <= i2cbs_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

endmodule

`default_nettype wire

@@ bench/i2c_master_bit_sequencer_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the I2C master bit sequencer: a queue-fed tick driver, a stall
// generator and a monitor that checks every result transfer against a cycle predictor.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer.

module i2c_master_bit_sequencer_test;

    localparam logic [2:0] CMD_RESERVED = 3'd7;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [16:0] COUNT_CAP = 17'h0FFFF;

    typedef struct packed {
        logic [15:0] timeout;
        logic [2:0]  operation;
        logic [2:0]  phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_reg;
        logic [7:0]  receive_reg;
        logic [15:0] wait_count;
        logic        scl_held;
        logic        sda_held;
        logic        ack_seen;
        logic        timed_out;
    } seq_state_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    i2cbs_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    i2cbs_pkg::out_item_t out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [15:0]          cfg_data = '0;

    i2cbs_pkg::in_item_t  tick_q[$];
    i2cbs_pkg::out_item_t expected_q[$];
    seq_state_t plan_st;
    seq_state_t live_st;
    bit         idle_on = 1'b1;
    bit         in_taken = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         mismatches = 0;
    int         cycles = 0;
    int         ticks_queued = 0;
    int         results_seen = 0;

    i2c_master_bit_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void sequence_tick(input seq_state_t cur,
                                          input i2cbs_pkg::in_item_t item,
                                          output seq_state_t nxt,
                                          output i2cbs_pkg::out_item_t res);
        seq_state_t  s;
        logic        scl;
        logic        sda;
        logic        busy;
        logic        done;
        logic [16:0] next_wait;
        s = cur;
        scl = s.scl_held;
        sda = s.sda_held;
        busy = 1'b0;
        done = 1'b0;
        next_wait = '0;
        if (s.operation == i2cbs_pkg::CMD_NONE && item.command != i2cbs_pkg::CMD_NONE
            && item.command != CMD_RESERVED)
        begin
            s.operation = item.command;
            s.phase = (item.command == i2cbs_pkg::CMD_WAIT_ACK) ?
                      i2cbs_pkg::PH_ACK_LOW : i2cbs_pkg::PH_CLK_LOW;
            s.bit_count = '0;
            s.shift_reg = '0;
            if (item.command == i2cbs_pkg::CMD_SEND_BYTE)
                s.shift_reg = item.tx_byte;
            if (item.command == i2cbs_pkg::CMD_SEND_ACK)
                s.shift_reg = {7'd0, ~item.ack_to_send};
            if (item.command == i2cbs_pkg::CMD_SEND_BYTE
                || item.command == i2cbs_pkg::CMD_WAIT_ACK)
            begin
                s.ack_seen = 1'b0;
                s.timed_out = 1'b0;
                s.wait_count = '0;
            end
        end
        if (s.operation != i2cbs_pkg::CMD_NONE)
        begin
            busy = 1'b1;
            case (s.operation)
                i2cbs_pkg::CMD_START:
                begin
                    scl = 1'b1;
                    if (s.phase == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        sda = 1'b1;
                        s.phase = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        sda = 1'b0;
                        done = 1'b1;
                        s.scl_held = 1'b0;
                        s.sda_held = 1'b0;
                    end
                end
                i2cbs_pkg::CMD_STOP:
                begin
                    scl = 1'b1;
                    if (s.phase == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        sda = 1'b0;
                        s.phase = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        sda = 1'b1;
                        done = 1'b1;
                        s.scl_held = 1'b1;
                        s.sda_held = 1'b1;
                    end
                end
                i2cbs_pkg::CMD_SEND_ACK:
                begin
                    sda = s.shift_reg[0];
                    if (s.phase == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        scl = 1'b0;
                        s.phase = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        scl = 1'b1;
                        done = 1'b1;
                        s.scl_held = 1'b0;
                        s.sda_held = sda;
                    end
                end
                i2cbs_pkg::CMD_RECV_BYTE:
                begin
                    sda = 1'b1;
                    if (s.phase == i2cbs_pkg::PH_CLK_LOW)
                    begin
                        scl = 1'b0;
                        s.phase = i2cbs_pkg::PH_CLK_HIGH;
                    end
                    else
                    begin
                        scl = 1'b1;
                        s.shift_reg = {s.shift_reg[6:0], item.sda_in};
                        s.bit_count = s.bit_count + 4'd1;
                        if (s.bit_count >= 4'd8)
                        begin
                            s.receive_reg = s.shift_reg;
                            done = 1'b1;
                            s.scl_held = 1'b0;
                            s.sda_held = 1'b1;
                        end
                        else
                            s.phase = i2cbs_pkg::PH_CLK_LOW;
                    end
                end
                default:
                begin
                    if (s.phase == i2cbs_pkg::PH_CLK_LOW || s.phase == i2cbs_pkg::PH_CLK_HIGH)
                    begin
                        sda = s.shift_reg[7];
                        if (s.phase == i2cbs_pkg::PH_CLK_LOW)
                        begin
                            scl = 1'b0;
                            s.phase = i2cbs_pkg::PH_CLK_HIGH;
                        end
                        else
                        begin
                            scl = 1'b1;
                            s.shift_reg = {s.shift_reg[6:0], 1'b0};
                            s.bit_count = s.bit_count + 4'd1;
                            s.phase = (s.bit_count >= 4'd8) ?
                                      i2cbs_pkg::PH_ACK_LOW : i2cbs_pkg::PH_CLK_LOW;
                        end
                    end
                    else if (s.phase == i2cbs_pkg::PH_ACK_LOW)
                    begin
                        scl = 1'b0;
                        sda = 1'b1;
                        s.phase = i2cbs_pkg::PH_ACK_POLL;
                    end
                    else if (s.phase == i2cbs_pkg::PH_ACK_POLL)
                    begin
                        scl = 1'b1;
                        sda = 1'b1;
                        next_wait = {1'b0, s.wait_count} + 17'd1;
                        if (!item.sda_in)
                        begin
                            s.ack_seen = 1'b1;
                            s.phase = i2cbs_pkg::PH_ACK_DONE;
                        end
                        else if (next_wait >= {1'b0, s.timeout} || next_wait >= COUNT_CAP)
                        begin
                            s.timed_out = 1'b1;
                            s.phase = i2cbs_pkg::PH_ACK_DONE;
                        end
                        else
                            s.wait_count = next_wait[15:0];
                    end
                    else
                    begin
                        scl = 1'b1;
                        sda = 1'b1;
                        done = 1'b1;
                        s.scl_held = 1'b0;
                        s.sda_held = 1'b1;
                    end
                end
            endcase
            if (done)
            begin
                s.operation = i2cbs_pkg::CMD_NONE;
                s.phase = i2cbs_pkg::PH_CLK_LOW;
            end
        end
        res.scl_level = scl;
        res.sda_level = sda;
        res.busy_res = busy;
        res.done_res = done;
        res.rx_byte = s.receive_reg;
        res.ack_seen = s.ack_seen;
        res.timed_out = s.timed_out;
        nxt = s;
    endfunction

    task automatic push_tick(input i2cbs_pkg::in_item_t item);
        i2cbs_pkg::out_item_t unused;
        sequence_tick(plan_st, item, plan_st, unused);
        tick_q.push_back(item);
        ticks_queued++;
    endtask

    // The slave holds SDA high for the first polls_high polls of an acknowledge wait.
    task automatic queue_operation(input logic [2:0] cmd, input logic [7:0] txb,
                                   input logic ack, input int polls_high);
        i2cbs_pkg::in_item_t item;
        int                  polls;
        polls = 0;
        item.command = cmd;
        item.tx_byte = txb;
        item.ack_to_send = ack;
        item.sda_in = 1'($urandom_range(0, 1));
        push_tick(item);
        while (plan_st.operation != i2cbs_pkg::CMD_NONE)
        begin
            item.command = 3'($urandom_range(0, 7));
            item.tx_byte = 8'($urandom_range(0, 255));
            item.ack_to_send = 1'($urandom_range(0, 1));
            if (plan_st.phase == i2cbs_pkg::PH_ACK_POLL)
            begin
                item.sda_in = (polls < polls_high);
                polls++;
            end
            else
                item.sda_in = 1'($urandom_range(0, 1));
            push_tick(item);
        end
    endtask

    task automatic queue_random_ops(input int count);
        int goal;
        goal = ticks_queued + count;
        while (ticks_queued < goal)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_operation($urandom_range(0, 1) ? i2cbs_pkg::CMD_NONE : CMD_RESERVED,
                                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
            else
                queue_operation(3'($urandom_range(1, 6)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                            : $urandom_range(0, 6));
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        while (results_seen < ticks_queued)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        wait_for_drain();
        cfg_data <= ticks;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        plan_st.timeout = ticks;
        live_st.timeout = ticks;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (tick_q.size() != 0)
            begin
                in_data <= tick_q.pop_front();
                in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 11) == 0)
                    send_gap <= $urandom_range(1, 14);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 11) == 0)
                recv_gap <= $urandom_range(1, 14);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        i2cbs_pkg::out_item_t want;
        i2cbs_pkg::out_item_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            in_taken = in_valid && !in_stall;
            if (rst_n && in_taken)
            begin
                sequence_tick(live_st, in_data, live_st, want);
                expected_q.push_back(want);
            end
            if (rst_n && out_valid && !out_stall)
            begin
                got = out_data;
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result transfer with nothing expected: %h", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level
                        || got.busy_res !== want.busy_res || got.done_res !== want.done_res
                        || got.rx_byte !== want.rx_byte || got.ack_seen !== want.ack_seen
                        || got.timed_out !== want.timed_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch (expected/actual): scl %b/%b sda %b/%b",
                                      " busy %b/%b done %b/%b rx %h/%h ack %b/%b tmo %b/%b"},
                                     want.scl_level, got.scl_level,
                                     want.sda_level, got.sda_level,
                                     want.busy_res, got.busy_res,
                                     want.done_res, got.done_res,
                                     want.rx_byte, got.rx_byte,
                                     want.ack_seen, got.ack_seen,
                                     want.timed_out, got.timed_out);
                    end
                end
            end
        end
    end

    initial
    begin
        int          phase_no;
        logic [15:0] ticks;
        plan_st = '0;
        plan_st.timeout = i2cbs_pkg::TIMEOUT_RESET;
        plan_st.scl_held = 1'b1;
        plan_st.sda_held = 1'b1;
        live_st = plan_st;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_operation(i2cbs_pkg::CMD_NONE, 8'h00, 1'b0, 0);
        queue_operation(CMD_RESERVED, 8'hFF, 1'b1, 0);
        queue_operation(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 0);
        queue_operation(i2cbs_pkg::CMD_SEND_BYTE, 8'hFF, 1'b0, 0);
        queue_operation(i2cbs_pkg::CMD_RECV_BYTE, 8'h00, 1'b1, 0);
        queue_operation(i2cbs_pkg::CMD_SEND_ACK, 8'h00, 1'b1, 0);
        queue_operation(i2cbs_pkg::CMD_SEND_ACK, 8'hFF, 1'b0, 0);
        queue_operation(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 3);
        queue_operation(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 0);

        // A zero timeout gives up after the first high poll, as a timeout of one does.
        set_timeout(16'd0);
        queue_operation(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 4);
        queue_operation(i2cbs_pkg::CMD_SEND_BYTE, 8'h00, 1'b1, 4);

        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            case (phase_no)
                0: ticks = 16'd1;
                1: ticks = 16'hFFFF;
                3: ticks = 16'($urandom_range(0, 65535));
                default: ticks = 16'($urandom_range(2, 40));
            endcase
            set_timeout(ticks);
            idle_on = (phase_no != 4);
            queue_random_ops(130);
            if (phase_no == 1)
                hold_requests++;
            if (phase_no == 2)
                wait_for_drain();
            queue_random_ops(130);
        end

        set_timeout(16'd64);
        idle_on = 1'b0;
        queue_operation(i2cbs_pkg::CMD_WAIT_ACK, 8'h00, 1'b0, 200);
        queue_operation(i2cbs_pkg::CMD_SEND_BYTE, 8'hC3, 1'b1, 1);
        queue_operation(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 0);
        wait_for_drain();

        if (mismatches == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
